[sv/ising_metropolis_spin_update_top_assert.svh]
// Assertion macros for the Ising spin update block and its checker.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_TOP_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IMS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ims check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ims check failed");

`endif

[sv/ims_pkg.sv]
// Shared constants, codes and types of the Ising spin update block.
package ims_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int AREA_W      = $clog2(STORE_DEPTH + 1);
    localparam int EFF_W       = $clog2(MAX_SIDE + 1);

    localparam int SIDE_W  = 7;
    localparam int COEF_W  = 12;
    localparam int SITE_W  = 12;
    localparam int RND_W   = 16;
    localparam int DE_W    = 16;
    localparam int P_W     = 15;
    localparam int NSUM_W  = 4;
    localparam int JN_W    = COEF_W + NSUM_W;
    localparam int CALC_W  = ((SITE_W > AREA_W) ? SITE_W : AREA_W) + 1;
    localparam int NUM_THR = 10;
    localparam int THR_W   = 16;
    localparam int ENT_W   = $clog2(NUM_THR);
    localparam int OUTC_W  = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING_J   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_H      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_A     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_B     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_C     = 3'd5;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUT_FLIPPED  = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_REJECTED = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_OOR      = 2'd2;

    localparam logic [THR_W-1:0] THR_ALWAYS = '1;

    // Microprogram steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FETCH    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RD_SELF  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_RD_LEFT  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_RD_RIGHT = 4'd3;
    localparam logic [STEP_W-1:0] STEP_RD_UP    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_RD_DOWN  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ACC      = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CALC     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DECIDE   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_COMMIT   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_OOR      = 4'd10;

    typedef enum logic [2:0] {
        ASEL_SELF,
        ASEL_LEFT,
        ASEL_RIGHT,
        ASEL_UP,
        ASEL_DOWN
    } addr_sel_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_NO_INPUT,
        JC_OOR,
        JC_OUT_BUSY
    } jcond_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_TRIAL,
        EMIT_OOR
    } emit_t;

    // One microcode control word
    typedef struct packed {
        logic              take;
        logic              rd_en;
        addr_sel_t         asel;
        logic              cap_self;
        logic              acc;
        logic              calc_p;
        logic              decide;
        emit_t             emit;
        jcond_t            jc;
        logic [STEP_W-1:0] target;
        logic              done;
    } ctl_t;

    // Conditions seen by the sequencer
    typedef struct packed {
        logic in_take;
        logic oor;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        logic [EFF_W-1:0]                   side;
        logic [AREA_W-1:0]                  area;
        logic signed [COEF_W-1:0]           coupling;
        logic signed [COEF_W-1:0]           field;
        logic [NUM_THR-1:0][THR_W-1:0]      thr;
    } cfg_t;

    typedef struct packed {
        logic [OUTC_W-1:0]      outcome;
        logic                   new_spin;
        logic signed [DE_W-1:0] energy_change;
    } res_t;

endpackage

[sv/ims_stream_if.sv]
// Valid/ready channel interfaces for trial items and result items.
interface ims_in_if import ims_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SITE_W-1:0] site_index;
    logic [RND_W-1:0]  random_value;

    modport source (output valid, site_index, random_value, input ready);
    modport sink (input valid, site_index, random_value, output ready);
endinterface

interface ims_out_if import ims_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OUTC_W-1:0]      outcome;
    logic                   new_spin;
    logic signed [DE_W-1:0] energy_change;

    modport source (output valid, outcome, new_spin, energy_change, input ready);
    modport sink (input valid, outcome, new_spin, energy_change, output ready);
endinterface

[sv/ims_spin_mem.sv]
// Spin memory, one bit per site, with a set-to-up sweep after reset.
module ims_spin_mem import ims_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data,
    output logic              busy
);

    logic              mem [STORE_DEPTH];
    logic [ADDR_W:0]   clr_reg;
    logic [ADDR_W:0]   clr_next;
    logic              rd_data_reg;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic              wd;

    assign busy     = !clr_reg[ADDR_W];
    assign clr_next = busy ? clr_reg + 1'b1 : clr_reg;

    // Sweep owns the write port until every spin is up
    assign we = busy || wr_en;
    assign wa = busy ? clr_reg[ADDR_W-1:0] : wr_addr;
    assign wd = busy ? 1'b1 : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/ims_ucode_seq.sv]
// Microprogram store and step counter with conditional jumps.
module ims_ucode_seq import ims_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic              jump;

    function automatic ctl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctl_t w;
        w = '0;
        unique case (step)
            STEP_FETCH:
            begin
                w.take   = 1'b1;
                w.jc     = JC_NO_INPUT;
                w.target = STEP_FETCH;
            end
            STEP_RD_SELF:
            begin
                w.rd_en  = 1'b1;
                w.asel   = ASEL_SELF;
                w.jc     = JC_OOR;
                w.target = STEP_OOR;
            end
            STEP_RD_LEFT:
            begin
                w.rd_en    = 1'b1;
                w.asel     = ASEL_LEFT;
                w.cap_self = 1'b1;
            end
            STEP_RD_RIGHT:
            begin
                w.rd_en = 1'b1;
                w.asel  = ASEL_RIGHT;
                w.acc   = 1'b1;
            end
            STEP_RD_UP:
            begin
                w.rd_en = 1'b1;
                w.asel  = ASEL_UP;
                w.acc   = 1'b1;
            end
            STEP_RD_DOWN:
            begin
                w.rd_en = 1'b1;
                w.asel  = ASEL_DOWN;
                w.acc   = 1'b1;
            end
            STEP_ACC:
            begin
                w.acc = 1'b1;
            end
            STEP_CALC:
            begin
                w.calc_p = 1'b1;
            end
            STEP_DECIDE:
            begin
                w.decide = 1'b1;
            end
            STEP_COMMIT:
            begin
                w.emit   = EMIT_TRIAL;
                w.jc     = JC_OUT_BUSY;
                w.target = STEP_COMMIT;
                w.done   = 1'b1;
            end
            STEP_OOR:
            begin
                w.emit   = EMIT_OOR;
                w.jc     = JC_OUT_BUSY;
                w.target = STEP_OOR;
                w.done   = 1'b1;
            end
            default:
            begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

    assign ctl = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (ctl.jc)
            JC_NONE:     jump = 1'b0;
            JC_NO_INPUT: jump = !stat.in_take;
            JC_OOR:      jump = stat.oor;
            JC_OUT_BUSY: jump = stat.out_busy;
            default:     jump = 1'b0;
        endcase

        if (jump)
        begin
            pc_next = ctl.target;
        end
        else if (ctl.done)
        begin
            pc_next = STEP_FETCH;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[sv/ims_datapath.sv]
// Trial datapath: neighbour addressing, energy arithmetic and decision.
module ims_datapath import ims_pkg::*; (
    input  logic              clk,
    input  ctl_t              ctl,
    input  cfg_t              cfg,
    input  logic              in_take,
    input  logic [SITE_W-1:0] in_site,
    input  logic [RND_W-1:0]  in_rnd,
    input  logic              emit_fire,
    input  logic              rd_data,
    output logic              oor,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic              wr_data,
    output res_t              res
);

    logic [SITE_W-1:0]        site_reg;
    logic [RND_W-1:0]         rnd_reg;
    logic                     self_reg;
    logic signed [NSUM_W-1:0] nsum_reg;
    logic signed [P_W-1:0]    p_reg;
    logic signed [DE_W-1:0]   de_reg;
    logic                     flip_reg;

    logic [CALC_W-1:0] s_w, a_w, w_w;
    logic [CALC_W-1:0] lf, rt, up, dn, rt_raw, dn_raw;
    logic signed [JN_W-1:0]   jn;
    logic signed [DE_W-1:0]   p2, de;
    logic [ENT_W-1:0]         ent;
    logic [THR_W-1:0]         th;
    logic                     flip;

    assign s_w = CALC_W'(site_reg);
    assign a_w = CALC_W'(cfg.area);
    assign w_w = CALC_W'(cfg.side);

    assign oor = s_w >= a_w;

    // Neighbours wrap over the flat index, so the boundary is helical
    assign rt_raw = s_w + CALC_W'(1);
    assign dn_raw = s_w + w_w;
    assign lf = (s_w == '0) ? a_w - CALC_W'(1) : s_w - CALC_W'(1);
    assign rt = (rt_raw >= a_w) ? rt_raw - a_w : rt_raw;
    assign up = (s_w < w_w) ? s_w + a_w - w_w : s_w - w_w;
    assign dn = (dn_raw >= a_w) ? dn_raw - a_w : dn_raw;

    assign rd_en = ctl.rd_en;

    always_comb
    begin
        unique case (ctl.asel)
            ASEL_SELF:  rd_addr = ADDR_W'(s_w);
            ASEL_LEFT:  rd_addr = ADDR_W'(lf);
            ASEL_RIGHT: rd_addr = ADDR_W'(rt);
            ASEL_UP:    rd_addr = ADDR_W'(up);
            ASEL_DOWN:  rd_addr = ADDR_W'(dn);
            default:    rd_addr = ADDR_W'(s_w);
        endcase
    end

    assign jn = cfg.coupling * nsum_reg;
    assign p2 = DE_W'(p_reg) <<< 1;
    assign de = self_reg ? p2 : -p2;

    // Threshold entry: neighbour sum offset to 0..8, plus one for spin up
    assign ent  = ENT_W'(unsigned'(nsum_reg) + 4'd4) + ENT_W'(self_reg);
    assign th   = cfg.thr[ent];
    assign flip = de[DE_W-1] || (th == THR_ALWAYS) || (rnd_reg < th);

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            site_reg <= in_site;
            rnd_reg  <= in_rnd;
        end
        if (ctl.cap_self)
        begin
            self_reg <= rd_data;
            nsum_reg <= '0;
        end
        else if (ctl.acc)
        begin
            nsum_reg <= rd_data ? nsum_reg + 4'sd1 : nsum_reg - 4'sd1;
        end
        if (ctl.calc_p)
        begin
            p_reg <= P_W'(jn) + P_W'(cfg.field);
        end
        if (ctl.decide)
        begin
            de_reg   <= de;
            flip_reg <= flip;
        end
    end

    assign wr_en   = emit_fire && (ctl.emit == EMIT_TRIAL) && flip_reg;
    assign wr_addr = ADDR_W'(site_reg);
    assign wr_data = !self_reg;

    always_comb
    begin
        if (ctl.emit == EMIT_OOR)
        begin
            res.outcome       = OUT_OOR;
            res.new_spin      = 1'b0;
            res.energy_change = '0;
        end
        else
        begin
            res.outcome       = flip_reg ? OUT_FLIPPED : OUT_REJECTED;
            res.new_spin      = self_reg ^ flip_reg;
            res.energy_change = de_reg;
        end
    end

endmodule

[sv/ising_metropolis_spin_update_top.sv]
// Top level of the Metropolis single-spin-flip trial block for a 2D Ising lattice.
// Each item on in_ch is one trial at site_index: the block reads the spin and its
// four neighbours (flat index -1, +1, -side, +side, wrapped over side*side),
// forms deltaE = 2*s*(J*sum + H) in Q8.8, flips on negative deltaE or when
// random_value falls below the loaded threshold (all ones accepts always), and
// returns one result item on out_ch. A site at or beyond side*side gives outcome
// "out of range" and changes nothing. A trial walks the microprogram one step a
// cycle: five reads on the single read port of the spin memory, then the
// arithmetic steps; an out-of-range item ends after its first read. The walk
// holds while the result item waits for out_ch.ready, and no new item is taken
// before the last result is emitted. After reset the block sweeps the spin memory
// to all up, one site a cycle, and holds in_ch.ready low meanwhile; configuration
// writes are taken at any time and must only be made while no item is in flight.
module ising_metropolis_spin_update_top import ims_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ims_in_if.sink                in_ch,
    ims_out_if.source             out_ch
);

    // Configuration registers
    logic [SIDE_W-1:0]        side_reg;
    logic signed [COEF_W-1:0] coupling_reg;
    logic signed [COEF_W-1:0] field_reg;
    logic [63:0]              word_a_reg;
    logic [63:0]              word_b_reg;
    logic [31:0]              word_c_reg;
    logic [AREA_W-1:0]        area_reg;
    logic [EFF_W-1:0]         side_eff;

    // Result register
    logic out_valid_reg;
    logic out_valid_next;
    res_t out_res_reg;

    ctl_t              ctl;
    stat_t             stat;
    cfg_t              cfg;
    res_t              res;
    logic              mem_busy;
    logic              in_take;
    logic              out_busy;
    logic              emit_fire;
    logic              rd_en, rd_data, wr_en, wr_data;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    // Clamp the side to 2..MAX_SIDE
    always_comb
    begin
        if (side_reg < SIDE_W'(2))
        begin
            side_eff = EFF_W'(2);
        end
        else if (32'(side_reg) > 32'(MAX_SIDE))
        begin
            side_eff = EFF_W'(MAX_SIDE);
        end
        else
        begin
            side_eff = EFF_W'(side_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg     <= SIDE_W'(64);
            coupling_reg <= COEF_W'(256);
            field_reg    <= '0;
            word_a_reg   <= '0;
            word_b_reg   <= '0;
            word_c_reg   <= '0;
            area_reg     <= AREA_W'(STORE_DEPTH);
        end
        else
        begin
            // Area is registered from the clamped side in the cycle after it changes, before an item uses it
            area_reg <= AREA_W'(side_eff) * AREA_W'(side_eff);
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_LATTICE_SIDE: side_reg     <= cfg_data[SIDE_W-1:0];
                    REG_COUPLING_J:   coupling_reg <= cfg_data[COEF_W-1:0];
                    REG_FIELD_H:      field_reg    <= cfg_data[COEF_W-1:0];
                    REG_ACCEPT_A:     word_a_reg   <= cfg_data;
                    REG_ACCEPT_B:     word_b_reg   <= cfg_data;
                    REG_ACCEPT_C:     word_c_reg   <= cfg_data[31:0];
                    default:          ;
                endcase
            end
        end
    end

    assign cfg.side     = side_eff;
    assign cfg.area     = area_reg;
    assign cfg.coupling = coupling_reg;
    assign cfg.field    = field_reg;
    assign cfg.thr      = {word_c_reg, word_b_reg, word_a_reg};

    // Input side: take an item only at the fetch step and after the sweep
    assign in_ch.ready = ctl.take && !mem_busy;
    assign in_take     = in_ch.valid && in_ch.ready;

    // Output side: a held result blocks the next emit until it is taken
    assign out_busy  = out_valid_reg && !out_ch.ready;
    assign emit_fire = (ctl.emit != EMIT_NONE) && !out_busy;

    always_comb
    begin
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.outcome       = out_res_reg.outcome;
    assign out_ch.new_spin      = out_res_reg.new_spin;
    assign out_ch.energy_change = out_res_reg.energy_change;

    assign stat.in_take  = in_take;
    assign stat.out_busy = out_busy;

    ims_ucode_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    ims_datapath u_dp (
        .clk       (clk),
        .ctl       (ctl),
        .cfg       (cfg),
        .in_take   (in_take),
        .in_site   (in_ch.site_index),
        .in_rnd    (in_ch.random_value),
        .emit_fire (emit_fire),
        .rd_data   (rd_data),
        .oor       (stat.oor),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res       (res)
    );

    ims_spin_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (mem_busy)
    );

endmodule

[sv/ims_checker.sv]
// Port-level checker for the Ising spin update block, bound to its top level.
`include "ising_metropolis_spin_update_top_assert.svh"

module ims_checker import ims_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [OUTC_W-1:0]      outcome,
    input logic                   new_spin,
    input logic signed [DE_W-1:0] energy_change
);

    // A result item stays offered until taken
    `IMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // An out-of-range item reports down spin and no energy change
    `IMS_ASSERT_IMPLIES(a_oor_zero, out_valid && (outcome == OUT_OOR), !new_spin && (energy_change == '0))

    // A rejected trial never had a negative energy change
    `IMS_ASSERT_IMPLIES(a_reject_nonneg, out_valid && (outcome == OUT_REJECTED), !energy_change[DE_W-1])

    // One trial at a time: no acceptance in the cycle after one
    `IMS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind ising_metropolis_spin_update_top ims_checker u_ims_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .outcome       (out_ch.outcome),
    .new_spin      (out_ch.new_spin),
    .energy_change (out_ch.energy_change)
);
